[hw/rtl/vpp_pkg.sv]
package vpp_pkg;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    REG_C00_01 = 3'd0,
    REG_C02_03 = 3'd1,
    REG_C10_11 = 3'd2,
    REG_C12_13 = 3'd3,
    REG_C20_21 = 3'd4,
    REG_C22_23 = 3'd5,
    REG_C30_31 = 3'd6,
    REG_C32_33 = 3'd7
  } reg_idx_e;

  localparam int RegIdxW = 3;
  localparam int CfgW    = 64;

  // Quotient magnitude bits; anything at or above 2^QuotW saturates the screen
  // value for every legal screen size and fraction width.
  localparam int QuotW = 33;

  // Width of the saturation input
  localparam int SatW = 68;

  function automatic logic signed [31:0] sat32(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = SatW'(64'sh7FFF_FFFF);
    lo = -hi - SatW'(64'sd1);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

[hw/rtl/vertex_perspective_project_core.sv]
// Perspective projection of one Q-format vertex to screen pixels.
// Pipeline from accepted input word to output word: 3 matrix stages,
//   1 divide setup, 33 divide stages one quotient bit each, 3 screen-map stages.
// Throughput: one word per cycle; the whole pipe holds only when the output
//   register is full and stalled.
// Reset: asynchronous active low; clears valid bits and loads the identity matrix.
module vertex_perspective_project_core #(
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080,
  parameter int FRAC_BITS     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vpp_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  logic [vpp_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            pos_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            screen_x_o,
  output logic signed [31:0]            screen_y_o,
  output logic                          w_zero_o
);
  import vpp_pkg::*;

  localparam logic [31:0] OneQ = 32'd1 << FRAC_BITS;
  localparam int WW  = $clog2(SCREEN_WIDTH + 1) + 1;
  localparam int HW  = $clog2(SCREEN_HEIGHT + 1) + 1;
  localparam int DW  = 32 + QuotW;   // divider remainder / trial width
  localparam int MW  = QuotW + 2;    // signed clamped quotient
  localparam int AW  = MW + 1;       // after +/- 1.0
  localparam int PXW = AW + WW;
  localparam int PYW = AW + HW;
  localparam logic signed [WW-1:0] WidthS  = WW'(SCREEN_WIDTH);
  localparam logic signed [HW-1:0] HeightS = HW'(SCREEN_HEIGHT);

  // ---------------------------------------------------------------------------
  // Coefficients. Rows are x, y and w; the z row has no effect on any result
  // and is not stored. [row][0] holds cols 0/1, [row][1] holds cols 2/3.
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0] coef_q [3][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0][0] <= {32'd0, OneQ};
      coef_q[0][1] <= '0;
      coef_q[1][0] <= {OneQ, 32'd0};
      coef_q[1][1] <= '0;
      coef_q[2][0] <= '0;
      coef_q[2][1] <= {OneQ, 32'd0};
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_C00_01: coef_q[0][0] <= cfg_wdata_i;
        REG_C02_03: coef_q[0][1] <= cfg_wdata_i;
        REG_C10_11: coef_q[1][0] <= cfg_wdata_i;
        REG_C12_13: coef_q[1][1] <= cfg_wdata_i;
        REG_C30_31: coef_q[2][0] <= cfg_wdata_i;
        REG_C32_33: coef_q[2][1] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves unless the output word is held.
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------------
  // S1: nine 32x32 products; column 3 times w = 1.0 is the coefficient itself.
  // ---------------------------------------------------------------------------
  logic                v1_q;
  logic signed [63:0]  prod_q [3][3];
  logic signed [31:0]  m3_q   [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= 64'(signed'(coef_q[r][0][31:0]))  * 64'(pos_x_i);
        prod_q[r][1] <= 64'(signed'(coef_q[r][0][63:32])) * 64'(pos_y_i);
        prod_q[r][2] <= 64'(signed'(coef_q[r][1][31:0]))  * 64'(pos_z_i);
        m3_q[r]      <= signed'(coef_q[r][1][63:32]);
      end
    end
  end

  // S2: exact row sums
  logic                v2_q;
  logic signed [65:0]  sum_q  [3];
  logic signed [31:0]  m3b_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= 66'(prod_q[r][0]) + 66'(prod_q[r][1]) + 66'(prod_q[r][2]);
        m3b_q[r] <= m3_q[r];
      end
    end
  end

  // S3: floor shift, add the w column, saturate -> clip coordinates
  logic                v3_q;
  logic signed [31:0]  clip_q [3];
  logic signed [66:0]  row_t  [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_t[r] = 67'(sum_q[r] >>> FRAC_BITS) + 67'(m3b_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        clip_q[r] <= sat32(SatW'(row_t[r]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S4: divide setup. Magnitudes, result signs, and the early overflow test:
  // a quotient of 2^QuotW or more is flagged there, clamped in P1 and saturates later.
  // ---------------------------------------------------------------------------
  logic [31:0]    abs_x, abs_y, abs_w;
  logic [DW-1:0]  dvd_x, dvd_y, dvs_lim;

  always_comb begin
    abs_x   = clip_q[0][31] ? 32'(-clip_q[0]) : 32'(clip_q[0]);
    abs_y   = clip_q[1][31] ? 32'(-clip_q[1]) : 32'(clip_q[1]);
    abs_w   = clip_q[2][31] ? 32'(-clip_q[2]) : 32'(clip_q[2]);
    dvd_x   = DW'(abs_x) << FRAC_BITS;
    dvd_y   = DW'(abs_y) << FRAC_BITS;
    dvs_lim = DW'(abs_w) << QuotW;
  end

  // Divider pipe: index i is the input of divide stage i; index QuotW the output.
  logic             dv_q [QuotW+1];
  logic             nx_q [QuotW+1];
  logic             ny_q [QuotW+1];
  logic             ox_q [QuotW+1];
  logic             oy_q [QuotW+1];
  logic             wz_q [QuotW+1];
  logic [DW-1:0]    rx_q [QuotW];
  logic [DW-1:0]    ry_q [QuotW];
  logic [31:0]      d_q  [QuotW];
  logic [QuotW-1:0] qx_q [1:QuotW];
  logic [QuotW-1:0] qy_q [1:QuotW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q[0] <= dvd_x;
      ry_q[0] <= dvd_y;
      d_q[0]  <= abs_w;
      nx_q[0] <= clip_q[0][31] ^ clip_q[2][31];
      ny_q[0] <= clip_q[1][31] ^ clip_q[2][31];
      ox_q[0] <= dvd_x >= dvs_lim;
      oy_q[0] <= dvd_y >= dvs_lim;
      wz_q[0] <= clip_q[2] == 32'sd0;
    end
  end

  // One restoring step per stage, quotient bit QuotW-1-i at stage i.
  for (genvar i = 0; i < QuotW; i++) begin : g_div
    logic [DW-1:0]    trial;
    logic             ge_x, ge_y;
    logic [QuotW-1:0] qx_prev, qy_prev;

    assign trial = DW'(d_q[i]) << (QuotW - 1 - i);
    assign ge_x  = rx_q[i] >= trial;
    assign ge_y  = ry_q[i] >= trial;

    if (i == 0) begin : g_first
      assign qx_prev = '0;
      assign qy_prev = '0;
    end else begin : g_rest
      assign qx_prev = qx_q[i];
      assign qy_prev = qy_q[i];
    end

    if (i < QuotW - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en) begin
          rx_q[i+1] <= ge_x ? rx_q[i] - trial : rx_q[i];
          ry_q[i+1] <= ge_y ? ry_q[i] - trial : ry_q[i];
          d_q[i+1]  <= d_q[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        qx_q[i+1] <= {qx_prev[QuotW-2:0], ge_x};
        qy_q[i+1] <= {qy_prev[QuotW-2:0], ge_y};
        nx_q[i+1] <= nx_q[i];
        ny_q[i+1] <= ny_q[i];
        ox_q[i+1] <= ox_q[i];
        oy_q[i+1] <= oy_q[i];
        wz_q[i+1] <= wz_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // P1: signed, clamped quotient, then x + 1.0 and 1.0 - y
  // ---------------------------------------------------------------------------
  logic [QuotW:0]        mag_x, mag_y;
  logic signed [MW-1:0]  q_x, q_y;
  logic                  p1_v_q, p1_wz_q;
  logic signed [AW-1:0]  ax_q, ay_q;

  always_comb begin
    mag_x = ox_q[QuotW] ? (QuotW+1)'(1) << QuotW : {1'b0, qx_q[QuotW]};
    mag_y = oy_q[QuotW] ? (QuotW+1)'(1) << QuotW : {1'b0, qy_q[QuotW]};
    q_x   = nx_q[QuotW] ? -signed'(MW'(mag_x)) : signed'(MW'(mag_x));
    q_y   = ny_q[QuotW] ? -signed'(MW'(mag_y)) : signed'(MW'(mag_y));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q    <= AW'(q_x) + signed'(AW'(OneQ));
      ay_q    <= signed'(AW'(OneQ)) - AW'(q_y);
      p1_wz_q <= wz_q[QuotW];
    end
  end

  // P2: scale by the screen size
  logic                   p2_v_q, p2_wz_q;
  logic signed [PXW-1:0]  px_q;
  logic signed [PYW-1:0]  py_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q    <= PXW'(ax_q) * PXW'(WidthS);
      py_q    <= PYW'(ay_q) * PYW'(HeightS);
      p2_wz_q <= p1_wz_q;
    end
  end

  // P3: halve with floor, saturate, zero on degenerate w -> output register
  logic signed [31:0] sx_q, sy_q;
  logic               wzo_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q  <= p2_wz_q ? 32'sd0 : sat32(SatW'(px_q >>> 1));
      sy_q  <= p2_wz_q ? 32'sd0 : sat32(SatW'(py_q >>> 1));
      wzo_q <= p2_wz_q;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= QuotW; i++) begin
        dv_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      dv_q[0] <= v3_q;
      for (int i = 0; i < QuotW; i++) begin
        dv_q[i+1] <= dv_q[i];
      end
      p1_v_q      <= dv_q[QuotW];
      p2_v_q      <= p1_v_q;
      out_valid_q <= p2_v_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign w_zero_o    = wzo_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_wz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && w_zero_o |-> screen_x_o == 32'sd0 && screen_y_o == 32'sd0)
    else $error("degenerate w word carries nonzero position");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output word");

  a_div_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0] && !wz_q[0] |-> d_q[0] != 32'd0)
    else $error("divider entered with zero divisor");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_q[QuotW]) && $stable(p1_v_q))
    else $error("pipeline moved during output stall");

endmodule
